@@ sv/qct_pkg.sv @@
package qct_pkg;

  // Longest command line that positions can address.
  localparam int unsigned MAX_LEN = 256;

  // Positions stop at the last command position and must fit the 8-bit field.
  localparam logic [7:0] POS_LIMIT = (MAX_LEN - 1 > 255) ? 8'd255 : 8'(MAX_LEN - 1);

  // Character codes that steer the splitter.
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;

  // One input beat.
  typedef struct packed {
    logic [7:0] in_char;
    logic       has_char;
    logic       end_of_command;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       new_word;
    logic [7:0] word_pos;
    logic       command_done;
  } out_beat_t;

  // Tokenizer state carried from one character to the next.
  typedef struct packed {
    logic [7:0] char_index;
    logic       in_quotes;
    logic       escape_pending;
    logic       word_open;
    logic       no_word_finished;
    logic [1:0] chars_in_first_word;
    logic [7:0] word_start;
  } state_t;

  localparam state_t STATE_RESET = '{
    char_index:          8'd0,
    in_quotes:           1'b0,
    escape_pending:      1'b0,
    word_open:           1'b0,
    no_word_finished:    1'b1,
    chars_in_first_word: 2'd0,
    word_start:          8'd0
  };

  // Increment that holds at the position limit.
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v >= POS_LIMIT) ? POS_LIMIT : v + 8'd1;
  endfunction

  // Word separators outside quoted mode.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

@@ sv/qct_in_if.sv @@
interface qct_in_if;
  import qct_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/qct_out_if.sv @@
interface qct_out_if;
  import qct_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/qct_step.sv @@
module qct_step (
  input  qct_pkg::state_t    state_i,
  input  qct_pkg::in_beat_t  beat_i,
  output qct_pkg::state_t    state_o,
  output qct_pkg::out_beat_t result_o,
  output logic               produce_o
);
  import qct_pkg::*;

  state_t     st;
  logic [7:0] idx;
  logic [7:0] ch;
  logic       emit;
  logic       is_new;

  // Classify the character and update the word tracking flags.
  always_comb begin
    st     = state_i;
    idx    = state_i.char_index;
    ch     = 8'd0;
    emit   = 1'b0;
    is_new = 1'b0;

    if (beat_i.has_char) begin
      st.char_index = sat_inc(idx);
      if (state_i.escape_pending) begin
        st.escape_pending = 1'b0;
        emit = 1'b1;
        if (beat_i.in_char == CH_LOWER_R) begin
          ch = CH_CR;
        end else if (beat_i.in_char == CH_LOWER_N) begin
          ch = CH_LF;
        end else begin
          ch = beat_i.in_char;
        end
      end else if (!state_i.in_quotes && is_space(beat_i.in_char)) begin
        if (state_i.word_open) begin
          st.word_open        = 1'b0;
          st.no_word_finished = 1'b0;
        end
      end else if (beat_i.in_char == CH_BACKSLASH) begin
        st.escape_pending = 1'b1;
        if (!state_i.word_open) begin
          st.word_start = idx;
        end
      end else begin
        if ((beat_i.in_char == CH_SQUOTE) || (beat_i.in_char == CH_DQUOTE)) begin
          st.in_quotes = !state_i.in_quotes;
        end
        if (!state_i.word_open) begin
          st.word_start = idx;
        end
        ch   = beat_i.in_char;
        emit = 1'b1;
      end
    end

    // A word character opens a word; the first word splits after its first character.
    if (emit) begin
      if (!st.word_open) begin
        is_new       = 1'b1;
        st.word_open = 1'b1;
      end
      if (st.no_word_finished) begin
        if (st.chars_in_first_word == 2'd1) begin
          is_new        = 1'b1;
          st.word_start = sat_inc(st.word_start);
        end
        if (st.chars_in_first_word < 2'd2) begin
          st.chars_in_first_word = st.chars_in_first_word + 2'd1;
        end
      end
    end

    result_o.out_char     = emit ? ch : 8'd0;
    result_o.char_valid   = emit;
    result_o.new_word     = emit && is_new;
    result_o.word_pos     = emit ? st.word_start : 8'd0;
    result_o.command_done = beat_i.end_of_command;

    produce_o = emit || beat_i.end_of_command;
    state_o   = beat_i.end_of_command ? STATE_RESET : st;
  end

endmodule

@@ sv/quoted_command_tokenizer.sv @@
// Quoted command tokenizer: splits a command line into words, shell style.
// The in_i channel takes one raw byte per beat with has_char and
// end_of_command flags; a beat with has_char low and end_of_command low is
// an idle beat and produces nothing. The out_o channel carries one beat per
// word character, tagged with a new-word mark and the word's start position,
// and command_done on the beat for the final input of a line, a beat of its
// own if that input yields no character. Unescaped separators outside quotes
// and unescaped backslashes yield no output beat unless they end a line. An
// accepted beat is held in an input register and processed from there; its
// result is registered in the output register when the held beat advances.
// One character is taken per cycle unless a stalled result holds it back.
// When the receiver stalls, the output register holds its beat and the input
// register stops only if its beat would need the output register; the input
// side stays ready while the input register is empty or draining.
// Reset clears both registers and returns the tokenizer to the start of a
// command line; every command_done beat returns it to the start as well.
module quoted_command_tokenizer (
  input logic       clk_i,
  input logic       rst_ni,
  qct_in_if.sink    in_i,
  qct_out_if.source out_o
);
  import qct_pkg::*;

  logic      in_vld_q;
  in_beat_t  in_beat_q;
  state_t    state_q;
  state_t    state_d;
  out_beat_t result_d;
  logic      produce;
  logic      advance;
  logic      out_vld_q;
  out_beat_t out_beat_q;

  qct_step u_step (
    .state_i  (state_q),
    .beat_i   (in_beat_q),
    .state_o  (state_d),
    .result_o (result_d),
    .produce_o(produce)
  );

  // The held beat moves on when it yields nothing or the output slot frees up.
  assign advance    = in_vld_q && (!produce || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_beat_q <= in_i.data;
    end
  end

  // Tokenizer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && produce) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      out_beat_q <= result_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_beat_q;

endmodule

@@ verif/qct_word_checker.sv @@
// Watches both channels of the tokenizer, predicts the result beat stream
// and compares every accepted result beat with the oldest predicted beat.
module qct_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  qct_in_if           in_i,
  qct_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import qct_pkg::*;

  // Predicted splitter state for the current command line.
  logic [7:0] line_pos;
  logic       quoted;
  logic       escaping;
  logic       word_open;
  logic       first_word;
  logic [1:0] lead_chars;
  logic [7:0] start_pos;

  out_beat_t   token_beats_due[$];
  int unsigned mismatch_total = 0;
  int unsigned beats_checked  = 0;
  int unsigned beats_pending  = 0;

  assign fail_count_o = mismatch_total;
  assign pending_o    = beats_pending;
  assign checked_o    = beats_checked;

  // Positions stop at the last addressable command position.
  function automatic logic [7:0] pos_step(input logic [7:0] v);
    if (v >= POS_LIMIT) return POS_LIMIT;
    return v + 8'd1;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  task automatic clear_line();
    line_pos   = '0;
    quoted     = 1'b0;
    escaping   = 1'b0;
    word_open  = 1'b0;
    first_word = 1'b1;
    lead_chars = '0;
    start_pos  = '0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_total++;
    if (mismatch_total <= 40)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Advances the predicted state by one input beat and queues its result.
  task automatic split_step(input in_beat_t b);
    logic       emit;
    logic       fresh;
    logic [7:0] ch;
    logic [7:0] idx;
    out_beat_t  r;
    emit  = 1'b0;
    fresh = 1'b0;
    ch    = '0;
    if (b.has_char) begin
      idx      = line_pos;
      line_pos = pos_step(line_pos);
      if (escaping) begin
        // The escaped byte always lands in the word, r and n translated.
        escaping = 1'b0;
        if (b.in_char == CH_LOWER_R) ch = CH_CR;
        else if (b.in_char == CH_LOWER_N) ch = CH_LF;
        else ch = b.in_char;
        emit = 1'b1;
      end else if (!quoted && is_blank(b.in_char)) begin
        if (word_open) begin
          word_open  = 1'b0;
          first_word = 1'b0;
        end
      end else if (b.in_char == CH_BACKSLASH) begin
        escaping = 1'b1;
        if (!word_open) start_pos = idx;
      end else begin
        if (b.in_char == CH_SQUOTE || b.in_char == CH_DQUOTE) quoted = !quoted;
        if (!word_open) start_pos = idx;
        ch   = b.in_char;
        emit = 1'b1;
      end
    end

    if (emit) begin
      if (!word_open) begin
        fresh     = 1'b1;
        word_open = 1'b1;
      end
      // The second character of the first word opens a word of its own.
      if (first_word) begin
        if (lead_chars == 2'd1) begin
          fresh     = 1'b1;
          start_pos = pos_step(start_pos);
        end
        if (lead_chars < 2'd2) lead_chars++;
      end
    end

    if (emit || b.end_of_command) begin
      r.out_char     = emit ? ch : 8'd0;
      r.char_valid   = emit;
      r.new_word     = emit && fresh;
      r.word_pos     = emit ? start_pos : 8'd0;
      r.command_done = b.end_of_command;
      token_beats_due = {token_beats_due, r};
    end
    if (b.end_of_command) clear_line();
  endtask

  // Results are checked before the same edge's input beat is predicted;
  // a result never belongs to a beat accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      clear_line();
      token_beats_due.delete();
      beats_pending = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (token_beats_due.size() == 0) begin
          report_mismatch("result beat with nothing due", int'(out_i.data), 0);
        end else begin
          want = token_beats_due.pop_front();
          beats_checked++;
          if (out_i.data.out_char !== want.out_char)
            report_mismatch("out_char", int'(out_i.data.out_char), int'(want.out_char));
          if (out_i.data.char_valid !== want.char_valid)
            report_mismatch("char_valid", int'(out_i.data.char_valid),
                            int'(want.char_valid));
          if (out_i.data.new_word !== want.new_word)
            report_mismatch("new_word", int'(out_i.data.new_word), int'(want.new_word));
          if (out_i.data.word_pos !== want.word_pos)
            report_mismatch("word_pos", int'(out_i.data.word_pos), int'(want.word_pos));
          if (out_i.data.command_done !== want.command_done)
            report_mismatch("command_done", int'(out_i.data.command_done),
                            int'(want.command_done));
        end
      end
      if (in_i.valid && in_i.ready) split_step(in_i.data);
      beats_pending = token_beats_due.size();
    end
  end

endmodule

@@ verif/quoted_command_tokenizer_tb.sv @@
// Drives command lines into the tokenizer with random idle cycles on both
// sides; the checker beside the block predicts and compares every result.
module quoted_command_tokenizer_tb;
  import qct_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic calm_run = 1'b0;

  int unsigned mismatches;
  int unsigned beats_due;
  int unsigned beats_checked;
  int unsigned beats_sent = 0;
  int unsigned lines_sent = 0;

  qct_in_if  in_ch ();
  qct_out_if out_ch ();

  quoted_command_tokenizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  qct_word_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (mismatches),
    .pending_o    (beats_due),
    .checked_o    (beats_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Generous bound on the whole run.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side stalls now and then, except in the calm stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= calm_run || ($urandom_range(99) >= 6);
    end
  end

  function automatic in_beat_t beat_of(input logic [7:0] c, input logic has,
                                       input logic last);
    in_beat_t b;
    b.in_char        = c;
    b.has_char       = has;
    b.end_of_command = last;
    return b;
  endfunction

  // Mostly shell-like text; a noisy line takes any byte at all.
  function automatic logic [7:0] pick_byte(input logic noisy);
    int r;
    r = $urandom_range(99);
    if (noisy || r < 10) return 8'($urandom_range(255));
    if (r < 50) return 8'h61 + 8'($urandom_range(25));
    if (r < 62) begin
      case ($urandom_range(3))
        0: return CH_SPACE;
        1: return CH_TAB;
        2: return CH_CR;
        default: return CH_LF;
      endcase
    end
    if (r < 70) return $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
    if (r < 78) return CH_BACKSLASH;
    if (r < 84) return $urandom_range(1) ? CH_LOWER_R : CH_LOWER_N;
    return 8'($urandom_range(126, 33));
  endfunction

  // One beat on the input channel, with an occasional idle cycle first.
  task automatic send_beat(input in_beat_t b);
    while (!calm_run && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (b.has_char || b.end_of_command) beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_beat(beat_of(s[i], 1'b1, i == s.len() - 1));
    lines_sent++;
  endtask

  // A random command line, now and then long enough to saturate positions.
  task automatic send_command();
    int   len;
    logic noisy;
    noisy = ($urandom_range(9) == 0);
    if (lines_sent == 40 || $urandom_range(149) == 0) len = $urandom_range(300, 258);
    else len = $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 3) send_beat(beat_of(8'($urandom_range(255)), 1'b0, 1'b0));
      send_beat(beat_of(pick_byte(noisy), 1'b1, 1'b0));
    end
    if ($urandom_range(9) < 3) send_beat(beat_of(8'($urandom_range(255)), 1'b0, 1'b1));
    else send_beat(beat_of(pick_byte(noisy), 1'b1, 1'b1));
    lines_sent++;
  endtask

  initial begin
    logic drained;
    drained      = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Byte extremes open the first word of a line that goes on with quotes,
    // escapes and ends on a separator.
    send_beat(beat_of(8'h00, 1'b1, 1'b0));
    send_beat(beat_of(8'hFF, 1'b1, 1'b0));
    send_text("ab \"c d\"\t\\n\\r\\q ");
    // Idle beat, then a line whose last byte is a lone backslash.
    send_beat(beat_of(8'hA5, 1'b0, 1'b0));
    send_text("x\\");
    // Bare end marker, then a one-character line.
    send_beat(beat_of(8'h5A, 1'b0, 1'b1));
    lines_sent++;
    send_beat(beat_of(8'h7E, 1'b1, 1'b1));
    lines_sent++;

    while (beats_sent < 1850) begin
      calm_run = (beats_sent >= 700 && beats_sent < 1000);
      // Once, hold the sender until every result has come back.
      if (!drained && beats_sent >= 1200) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (beats_due != 0) @(posedge clk_i);
      end
      send_command();
    end
    calm_run = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d input beats over %0d command lines; %0d result beats checked.",
             beats_sent, lines_sent, beats_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
